// ===== rtl/assert_macros.svh =====
// Assertion macros used by the box filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, sampled at the rising clock edge, off during reset.
`define BF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication check.
`define BF_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bf5_pkg.sv =====
// Shared types and constants of the 5x5 box filter.
`default_nettype none

package bf5_pkg;

  localparam int PIX_W     = 8;
  localparam int COORD_W   = 12;
  localparam int CFG_W     = 13;
  localparam int VSUM_W    = 11;   // five 8-bit samples
  localparam int TOTAL_W   = 13;   // 25 samples, at most 6375
  localparam int BORDER    = 2;

  // floor(x / 25) == (x * 5243) >> 17 for every x up to 6375
  localparam int RECIP_SHIFT = 17;
  localparam int PROD_W      = 26;
  localparam logic [TOTAL_W-1:0] RECIP_25 = 13'd5243;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

  // register index codes (paddr[2])
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_LW    = $clog2(Q_DEPTH + 1);

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  typedef struct packed {
    logic                pix;        // shifts the column sums
    logic                emit;       // produces a result beat
    logic                interior;   // window fully inside the image
    logic                frame_end;
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic [VSUM_W-1:0]   vsum;
  } bf5_entry_t;

  typedef struct packed {
    logic            empty;
    logic            full;
    logic [Q_LW-1:0] level;
  } bf5_q_stat_t;

endpackage

`default_nettype wire

// ===== rtl/bf5_ram.sv =====
// Generic single-write, single-read RAM with registered read (read-first).
`default_nettype none

module bf5_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/bf5_front.sv =====
// Front end: accepts beats, keeps raster counters, line buffers, builds queue entries.
`default_nettype none

module bf5_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [bf5_pkg::PIX_W-1:0] s_tdata,
  input  wire logic                      s_tuser,
  input  wire logic [bf5_pkg::CFG_W-1:0] cfg_width,
  input  wire logic [bf5_pkg::CFG_W-1:0] cfg_height,
  input  wire logic                      width_load,
  input  wire logic [bf5_pkg::CFG_W-1:0] width_value,
  input  wire bf5_pkg::bf5_q_stat_t      q_stat,
  output logic                           push,
  output bf5_pkg::bf5_entry_t            push_entry
);
  import bf5_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1) + 1;
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int LW = RW + CW + 1;
  localparam int SLOTS = 4;

  function automatic logic [CW-1:0] eff_w(input logic [CFG_W-1:0] v);
    logic [CW-1:0] r;
    if (v == '0) r = CW'(1);
    else if (32'(v) > 32'(MAX_WIDTH)) r = CW'(MAX_WIDTH);
    else r = CW'(v);
    return r;
  endfunction

  function automatic logic [RW-1:0] eff_h(input logic [CFG_W-1:0] v);
    logic [RW-1:0] r;
    if (v == '0) r = RW'(1);
    else if (32'(v) > 32'(MAX_HEIGHT)) r = RW'(MAX_HEIGHT);
    else r = RW'(v);
    return r;
  endfunction

  // raster state
  logic [CW-1:0] in_col, in_col_next;
  logic [RW-1:0] in_row, in_row_next;
  logic [CW-1:0] out_col, out_col_next;
  logic [RW-1:0] out_row, out_row_next;
  logic [LW-1:0] row_base, row_base_next;   // in_row * width

  // line buffer clear sweep
  logic          clr_busy;
  logic [AW-1:0] clr_addr;

  // stage waiting for line buffer read data
  logic             s1_valid;
  bf5_entry_t       s1_entry;
  logic [PIX_W-1:0] s1_pixel;

  logic [CW-1:0]    w;
  logic [RW-1:0]    h;
  logic             accept;
  logic             done0, done1;
  logic [CW-1:0]    ic0;
  logic [RW-1:0]    ir0;
  logic [CW-1:0]    oc0;
  logic [RW-1:0]    or0;
  logic [LW-1:0]    rb0;
  logic             in_done, is_drain, pix_go, emit_drain, pix_emit, emit;
  logic             interior, fend;
  logic [LW-1:0]    lin, thresh;
  logic [CW-1:0]    ic1, oc1;
  logic [RW-1:0]    ir1, or1;
  logic [LW-1:0]    rb1;
  bf5_entry_t       entry;

  logic [AW-1:0]    ram_addr;
  logic [PIX_W-1:0] ram_wdata;
  logic [PIX_W-1:0] ram_rdata [SLOTS];

  assign w = eff_w(cfg_width);
  assign h = eff_h(cfg_height);

  assign s_tready = !clr_busy &&
                    ((32'(q_stat.level) + 32'(s1_valid)) < 32'(Q_DEPTH));
  assign accept = s_tvalid && s_tready;

  always_comb begin
    // frame completed: counters return to zero
    done0 = (in_row >= h) && (out_row >= h);
    ic0 = done0 ? '0 : in_col;
    ir0 = done0 ? '0 : in_row;
    oc0 = done0 ? '0 : out_col;
    or0 = done0 ? '0 : out_row;
    rb0 = done0 ? '0 : row_base;

    in_done    = (ir0 >= h);
    is_drain   = (s_tuser == OP_DRAIN);
    emit_drain = in_done && is_drain;
    pix_go     = !in_done && !is_drain;

    lin      = rb0 + LW'(ic0);
    thresh   = (LW'(w) << 1) + LW'(2);
    pix_emit = pix_go && (lin >= thresh);
    emit     = emit_drain || pix_emit;

    interior = pix_emit &&
               (or0 >= RW'(BORDER)) &&
               ((RW+1)'(or0) + (RW+1)'(BORDER) < (RW+1)'(h)) &&
               (oc0 >= CW'(BORDER)) &&
               ((CW+1)'(oc0) + (CW+1)'(BORDER) < (CW+1)'(w));
    fend = ((RW+1)'(or0) + (RW+1)'(1) == (RW+1)'(h)) &&
           ((CW+1)'(oc0) + (CW+1)'(1) == (CW+1)'(w));

    oc1 = oc0;
    or1 = or0;
    if (emit) begin
      if ((CW+1)'(oc0) + (CW+1)'(1) >= (CW+1)'(w)) begin
        oc1 = '0;
        or1 = or0 + RW'(1);
      end else begin
        oc1 = oc0 + CW'(1);
      end
    end

    ic1 = ic0;
    ir1 = ir0;
    rb1 = rb0;
    if (pix_go) begin
      if ((CW+1)'(ic0) + (CW+1)'(1) >= (CW+1)'(w)) begin
        ic1 = '0;
        ir1 = ir0 + RW'(1);
        rb1 = rb0 + LW'(w);
      end else begin
        ic1 = ic0 + CW'(1);
      end
    end

    done1 = (ir1 >= h) && (or1 >= h);
    in_col_next   = done1 ? '0 : ic1;
    in_row_next   = done1 ? '0 : ir1;
    out_col_next  = done1 ? '0 : oc1;
    out_row_next  = done1 ? '0 : or1;
    row_base_next = done1 ? '0 : rb1;

    entry           = '0;
    entry.pix       = pix_go;
    entry.emit      = emit;
    entry.interior  = interior;
    entry.frame_end = emit && fend;
    entry.col       = COORD_W'(oc0);
    entry.row       = COORD_W'(or0);
  end

  // line buffers: one RAM per row slot, all read at the current column
  assign ram_addr  = clr_busy ? clr_addr : ic0[AW-1:0];
  assign ram_wdata = clr_busy ? '0 : s_tdata;

  for (genvar k = 0; k < SLOTS; k++) begin : g_slot
    logic slot_we;
    assign slot_we = clr_busy || (accept && pix_go && (ir0[1:0] == 2'(k)));
    bf5_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
    ) u_line (
      .clk   (clk),
      .we    (slot_we),
      .waddr (ram_addr),
      .wdata (ram_wdata),
      .raddr (ram_addr),
      .rdata (ram_rdata[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col   <= '0;
      in_row   <= '0;
      out_col  <= '0;
      out_row  <= '0;
      row_base <= '0;
      clr_busy <= 1'b1;
      clr_addr <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (clr_busy) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == AW'(MAX_WIDTH - 1)) begin
          clr_busy <= 1'b0;
        end
      end
      if (accept) begin
        in_col   <= in_col_next;
        in_row   <= in_row_next;
        out_col  <= out_col_next;
        out_row  <= out_row_next;
        row_base <= row_base_next;
      end else if (width_load) begin
        // rebase the linear position on the new width
        row_base <= LW'(LW'(in_row) * LW'(eff_w(width_value)));
      end
      s1_valid <= accept && (pix_go || emit_drain);
    end
    if (accept) begin
      s1_entry <= entry;
      s1_pixel <= s_tdata;
    end
  end

  always_comb begin
    push            = s1_valid;
    push_entry      = s1_entry;
    push_entry.vsum = VSUM_W'(s1_pixel) + VSUM_W'(ram_rdata[0]) + VSUM_W'(ram_rdata[1]) +
                      VSUM_W'(ram_rdata[2]) + VSUM_W'(ram_rdata[3]);
  end

endmodule

`default_nettype wire

// ===== rtl/bf5_fifo.sv =====
// Short queue of work entries between front and back end.
`default_nettype none

module bf5_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire bf5_pkg::bf5_entry_t  push_entry,
  input  wire logic                 pop,
  output bf5_pkg::bf5_entry_t       pop_entry,
  output bf5_pkg::bf5_q_stat_t      stat
);
  import bf5_pkg::*;

  bf5_entry_t      slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_LW-1:0] level;
  logic            do_push, do_pop;

  assign stat.level = level;
  assign stat.empty = (level == '0);
  assign stat.full  = (level == Q_LW'(Q_DEPTH));
  assign pop_entry  = slots[rd_ptr];

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + Q_AW'(1);
      if (do_pop)  rd_ptr <= rd_ptr + Q_AW'(1);
      case ({do_push, do_pop})
        2'b10:   level <= level + Q_LW'(1);
        2'b01:   level <= level - Q_LW'(1);
        default: level <= level;
      endcase
    end
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bf5_back.sv =====
// Back end: column sums, window total, divide by 25, output register.
`default_nettype none

module bf5_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire bf5_pkg::bf5_entry_t  q_entry,
  input  wire bf5_pkg::bf5_q_stat_t q_stat,
  output logic                      pop,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [31:0]               m_tdata,
  output logic                      m_tlast
);
  import bf5_pkg::*;

  localparam int COLS = 4;

  logic [VSUM_W-1:0]  csum [COLS];   // last four column sums
  logic [TOTAL_W-1:0] total;
  logic               a_valid, b_valid;
  bf5_entry_t         a_meta, b_meta;
  logic [PROD_W-1:0]  prod;
  logic               adv;
  logic [TOTAL_W-1:0] total_next;

  assign adv = !m_tvalid || m_tready;
  assign pop = adv && !q_stat.empty;

  assign total_next = TOTAL_W'(csum[0]) + TOTAL_W'(csum[1]) + TOTAL_W'(csum[2]) +
                      TOTAL_W'(csum[3]) + TOTAL_W'(q_entry.vsum);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      b_valid  <= 1'b0;
      m_tvalid <= 1'b0;
      total    <= '0;
      for (int i = 0; i < COLS; i++) begin
        csum[i] <= '0;
      end
    end else if (adv) begin
      a_valid  <= pop;
      b_valid  <= a_valid;
      m_tvalid <= b_valid && b_meta.emit;
      if (pop && q_entry.pix) begin
        for (int i = 0; i < COLS - 1; i++) begin
          csum[i] <= csum[i+1];
        end
        csum[COLS-1] <= q_entry.vsum;
        total        <= total_next;
      end
    end
    if (adv) begin
      a_meta  <= q_entry;
      b_meta  <= a_meta;
      prod    <= PROD_W'(total) * PROD_W'(RECIP_25);
      m_tdata <= {b_meta.row, b_meta.col,
                  b_meta.interior ? prod[RECIP_SHIFT +: PIX_W] : PIX_W'(0)};
      m_tlast <= b_meta.frame_end;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/box_filter_5x5_stream.sv =====
// Top level of the 5x5 box filter: config registers, front end, queue, back end.
`default_nettype none

// 5x5 box filter over a raster stream of 8-bit gray pixels. Each input beat
// carries one pixel (tuser = 0) or a drain request (tuser = 1). For each pixel
// position at least two pixels from every edge the result is floor(sum / 25)
// of its 5x5 neighborhood; border positions give 0. Results leave in raster
// order, two rows plus two pixels behind the input, with their column and row;
// tlast marks the last position of the frame. After the last pixel, each
// drain beat releases one of the trailing border results. Drains before the
// frame's input is complete, and pixels after it but before all results are
// out, are dropped. Sizes come from image_width (byte address 0) and
// image_height (address 4), 0 acting as 1 and values above MAX_WIDTH /
// MAX_HEIGHT clamped; write them only while the block is idle.
// Throughput is one beat per clock while s_tready is high: the four line
// buffers (one RAM per row slot) are all read at the current column in the
// accept cycle while the new pixel is written, so consecutive pixels never
// wait on each other. After the read at the accepting edge, the queue write,
// window sum, multiply by the reciprocal of 25 and output register follow,
// each registered, before m_tvalid rises. s_tready drops only when the
// four-entry queue, counting the entry being written, fills behind a stalled
// output, and while the line buffers are cleared after reset, one column of
// all four rows per clock.

module box_filter_5x5_stream #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,    // [7:0] pixel
  input  wire logic        s_tuser,    // [0] operation (0 pixel, 1 drain)
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,    // [7:0] filtered_value, [19:8] out_col, [31:20] out_row
  output logic             m_tlast,    // frame_end
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import bf5_pkg::*;

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic             cfg_wr;
  logic             reg_idx;
  logic             width_load;

  bf5_entry_t       q_push_entry;
  bf5_entry_t       q_pop_entry;
  bf5_q_stat_t      q_stat;
  logic             q_push;
  logic             q_pop;

  // result fields, for the checks
  logic [7:0]       res_value;
  logic [11:0]      res_col;
  logic [11:0]      res_row;
  logic             near_edge;

  // ---------------------------------------------------------------------
  // APB registers: write on the access cycle, no wait states
  // ---------------------------------------------------------------------
  assign pready     = 1'b1;
  assign reg_idx    = paddr[2];
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign width_load = cfg_wr && (reg_idx == REG_WIDTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_WIDTH:  image_width  <= pwdata[CFG_W-1:0];
        REG_HEIGHT: image_height <= pwdata[CFG_W-1:0];
        default:    image_width  <= image_width;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIDTH:  prdata = 32'(image_width);
      REG_HEIGHT: prdata = 32'(image_height);
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // front end: raster counters, result scheduling, line buffers
  // ---------------------------------------------------------------------
  bf5_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .cfg_width   (image_width),
    .cfg_height  (image_height),
    .width_load  (width_load),
    .width_value (pwdata[CFG_W-1:0]),
    .q_stat      (q_stat),
    .push        (q_push),
    .push_entry  (q_push_entry)
  );

  // queue decouples the front end from output backpressure
  bf5_fifo u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .pop_entry  (q_pop_entry),
    .stat       (q_stat)
  );

  // back end: running window and divide by 25
  bf5_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_entry  (q_pop_entry),
    .q_stat   (q_stat),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  assign res_value = m_tdata[7:0];
  assign res_col   = m_tdata[19:8];
  assign res_row   = m_tdata[31:20];
  assign near_edge = (res_col < 12'(BORDER)) || (res_row < 12'(BORDER));

  `include "assert_macros.svh"

  // the front end reserves queue space at accept time, so a push never finds it full
  `BF_ASSERT(a_queue_no_overflow, clk, rst, !(q_push && q_stat.full), "queue overflow")
  // the last position of a frame is a border position
  `BF_ASSERT_IMPL(a_frame_end_zero, clk, rst, m_tvalid && m_tlast, res_value == 8'd0, "frame end")
  // top rows and left columns are border
  `BF_ASSERT_IMPL(a_border_zero, clk, rst, m_tvalid && near_edge, res_value == 8'd0, "border")

endmodule

`default_nettype wire

// ===== dv/box_filter_5x5_stream_tb.sv =====
// Self-checking testbench of the 5x5 box filter stream: directed table, then random frames.
module box_filter_5x5_stream_tb;
  import bf5_pkg::*;

  // Sizes of the block as built (default parameters).
  localparam int MAXW = 4096;
  localparam int MAXH = 4096;
  localparam int AREA = 25;
  // Longest run of cycles with no beat on either side. It must outlast the
  // line-buffer clear after reset and the receiver hold-offs.
  localparam int STALL_LIMIT = 20000;
  localparam int RAND_ITEMS = 1700;

  // One result beat as it leaves the block.
  typedef struct packed {
    logic [7:0]  mean;
    logic [11:0] col;
    logic [11:0] row;
    logic        last;
  } mean_beat_t;

  // One row of the directed table; fixed rows carry their own expected outcome.
  typedef struct {
    op_t        op;
    logic [7:0] pix;
    bit         fixed;
    bit         has;
    mean_beat_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] pixel
  logic        s_tuser = 1'b0; // [0] operation (0 pixel, 1 drain)
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [7:0] mean, [19:8] col, [31:20] row
  logic        m_tlast;        // last position of the frame
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  box_filter_5x5_stream dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the line buffers, column sums, counters
  // and size registers.
  // ---------------------------------------------------------------------------
  logic [7:0]  line_mem [0:4*MAXW-1];
  int unsigned vcols [5];
  logic [12:0] width_reg = WIDTH_RESET;
  logic [12:0] height_reg = HEIGHT_RESET;
  int unsigned px_col = 0, px_row = 0;    // next input position
  int unsigned res_col = 0, res_row = 0;  // next result position
  mean_beat_t  pending_means [$];         // results still owed by the block

  // Stimulus and bookkeeping.
  int         tx_idle = 0;   // percent of cycles the sender holds back
  int         rx_idle = 0;   // percent of cycles the receiver holds back
  bit         hold_rx = 1'b0;
  bit         use_typed = 1'b0;
  bit         typed_has = 1'b0;
  mean_beat_t typed_res = '0;
  dir_row_t   dir_tab [$];
  int         err_cnt = 0;
  int         results_seen = 0;
  int         items_done = 0;
  int         frames_done = 0;
  int         quiet = 0;
  logic [7:0] rx_tick = '0;
  mean_beat_t seen, want;

  // 0 acts as 1, anything past the buffer size is clamped.
  function automatic int unsigned eff_dim(input logic [12:0] v, input int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  // Once input and output have both passed the last row, the frame is over.
  task automatic close_frame(input int unsigned h);
    if (px_row >= h && res_row >= h) begin
      px_col = 0;
      px_row = 0;
      res_col = 0;
      res_row = 0;
    end
  endtask

  task automatic take_result(input int unsigned v, input int unsigned w, input int unsigned h,
                             output mean_beat_t r);
    r.mean = 8'(v);
    r.col  = 12'(res_col);
    r.row  = 12'(res_row);
    r.last = (res_row + 1 == h) && (res_col + 1 == w);
    res_col++;
    if (res_col >= w) begin
      res_col = 0;
      res_row++;
    end
  endtask

  // One accepted input beat: took = beat changed state, got = a result is due.
  task automatic box_mean_step(input op_t op, input logic [7:0] pix,
                               output bit took, output bit got, output mean_beat_t r);
    int unsigned w, h, c, lin, total, vsum, val;
    w = eff_dim(width_reg, MAXW);
    h = eff_dim(height_reg, MAXH);
    took = 1'b0;
    got = 1'b0;
    r = '0;
    close_frame(h);
    if (px_row >= h) begin
      // input complete: drains release the trailing border, pixels are dropped
      if (op == OP_DRAIN) begin
        take_result(0, w, h, r);
        close_frame(h);
        took = 1'b1;
        got = 1'b1;
      end
    end else if (op == OP_PIXEL) begin
      c = (px_col < MAXW) ? px_col : MAXW - 1;
      vsum = pix;
      for (int k = 0; k < 4; k++) vsum += line_mem[((px_row + k) & 3) * MAXW + c];
      line_mem[(px_row & 3) * MAXW + c] = pix;
      for (int k = 0; k < 4; k++) vcols[k] = vcols[k+1];
      vcols[4] = vsum;
      total = 0;
      for (int k = 0; k < 5; k++) total += vcols[k];
      lin = px_row * w + px_col;
      if (lin >= 2 * w + 2) begin
        val = 0;
        if (res_row >= BORDER && res_row + BORDER < h &&
            res_col >= BORDER && res_col + BORDER < w)
          val = total / AREA;
        take_result(val, w, h, r);
        got = 1'b1;
      end
      px_col++;
      if (px_col >= w) begin
        px_col = 0;
        px_row++;
      end
      close_frame(h);
      took = 1'b1;
    end
  endtask

  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t %s mismatch: expected %0d, got %0d", $time, name, want_v, got_v);
      err_cnt++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Register access over APB: setup cycle, access cycle.
  // ---------------------------------------------------------------------------
  task automatic reg_read(input logic idx, input logic [12:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field(idx == REG_WIDTH ? "image_width" : "image_height", {19'd0, v}, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_write(input logic idx, input logic [12:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {19'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_WIDTH) width_reg = v;
    else height_reg = v;
    reg_read(idx, v);
  endtask

  // Block must be empty before a register write. Dropped beats make no result,
  // so give the pipeline time to settle after the last one.
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: random gaps, then hold the beat until it is taken. Prediction runs
  // at the accepting edge, so the stimulus can steer by the predicted state.
  // ---------------------------------------------------------------------------
  task automatic offer_beat(input op_t op, input logic [7:0] pix);
    bit took, got;
    mean_beat_t r;
    while ($urandom_range(99) < tx_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= pix;
    do @(posedge clk); while (!s_tready);
    box_mean_step(op, pix, took, got, r);
    if (use_typed) begin
      got = typed_has;
      r = typed_res;
    end
    if (got) pending_means.push_back(r);
    if (took) items_done++;
  endtask

  function automatic logic [12:0] pick_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) return 13'd0;
    if (r < 70) return 13'($urandom_range(8, 1));
    if (r < 95) return 13'($urandom_range(24, 9));
    return 13'($urandom_range(40, 25));
  endfunction

  task automatic add_row(input op_t op, input logic [7:0] pix, input bit fixed,
                         input bit has, input mean_beat_t res);
    dir_row_t row;
    row.op = op;
    row.pix = pix;
    row.fixed = fixed;
    row.has = has;
    row.res = res;
    dir_tab.push_back(row);
  endtask

  // One frame: raster pixels with some stray early drains, sometimes a size
  // change partway through, sometimes a stray pixel after the input is in,
  // then drains until the trailing border is out, sometimes one drain more.
  task automatic random_frame(input bit new_sizes, input bit may_break);
    int unsigned style;
    bit broke;
    logic [7:0] pv;
    if (new_sizes) begin
      wait_quiet();
      reg_write(REG_WIDTH, pick_dim());
      reg_write(REG_HEIGHT, pick_dim());
    end
    style = $urandom_range(3);
    broke = may_break && ($urandom_range(99) < 8);
    while (px_row < eff_dim(height_reg, MAXH)) begin
      if ($urandom_range(99) < 4) offer_beat(OP_DRAIN, 8'($urandom));
      if (broke && $urandom_range(99) < 10) begin
        // sizes change partway through the frame; counters wrap by the new ones
        broke = 1'b0;
        wait_quiet();
        if ($urandom_range(1)) reg_write(REG_WIDTH, pick_dim());
        else reg_write(REG_HEIGHT, pick_dim());
      end
      case (style)
        0: pv = 8'($urandom);
        1: pv = 8'hFF;
        2: pv = $urandom_range(1) ? 8'hFF : 8'h00;
        default: pv = 8'($urandom_range(3));
      endcase
      offer_beat(OP_PIXEL, pv);
    end
    if ($urandom_range(99) < 25) offer_beat(OP_PIXEL, 8'($urandom));
    while (px_row >= eff_dim(height_reg, MAXH)) offer_beat(OP_DRAIN, 8'($urandom));
    if ($urandom_range(99) < 10) offer_beat(OP_DRAIN, 8'($urandom));
    frames_done++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure; with hold_rx set it also holds off while
  // rx_tick[7:6] is 3, so the queue fills and s_tready drops.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rx_tick <= rx_tick + 8'd1;
    if (rst) m_tready <= 1'b0;
    else if (hold_rx && rx_tick[7:6] == 2'b11) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= rx_idle);
  end

  // Result checker: every result beat against the oldest owed result.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen = {m_tdata[7:0], m_tdata[19:8], m_tdata[31:20], m_tlast};
      if (pending_means.size() == 0) begin
        $display("%0t unexpected result: expected none, got mean %0d col %0d row %0d last %0b",
                 $time, seen.mean, seen.col, seen.row, seen.last);
        err_cnt++;
      end else begin
        want = pending_means.pop_front();
        check_field("mean", want.mean, seen.mean);
        check_field("col", want.col, seen.col);
        check_field("row", want.row, seen.row);
        check_field("last", want.last, seen.last);
        results_seen++;
      end
    end
  end

  // Watchdog: too long with no beat on either side ends the run.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("%0t watchdog: no beat in %0d cycles, %0d results owed",
               $time, quiet, pending_means.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int goal;
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (vcols[i]) vcols[i] = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset values, then a 5x5 image: one interior pixel at (2,2)
    reg_read(REG_WIDTH, WIDTH_RESET);
    reg_read(REG_HEIGHT, HEIGHT_RESET);
    tx_idle = 31;
    rx_idle = 45;
    reg_write(REG_WIDTH, 13'd5);
    reg_write(REG_HEIGHT, 13'd5);

    // Directed table. Pixel i releases result i-12; all-white image gives 255
    // at the center and 0 on the border.
    add_row(OP_DRAIN, 8'hA5, 1, 0, '0);              // drain before input is in: dropped
    for (int i = 0; i < 24; i++) add_row(OP_PIXEL, 8'hFF, i < 12, 0, '0);
    add_row(OP_PIXEL, 8'hFF, 1, 1, {8'd255, 12'd2, 12'd2, 1'b0});
    add_row(OP_PIXEL, 8'h00, 1, 0, '0);              // pixel while results owed: dropped
    for (int i = 0; i < 11; i++) add_row(OP_DRAIN, 8'hFF, 0, 0, '0);
    add_row(OP_DRAIN, 8'hFF, 1, 1, {8'd0, 12'd4, 12'd4, 1'b1});
    add_row(OP_DRAIN, 8'h5A, 1, 0, '0);              // nothing owed: counters clear, dropped
    foreach (dir_tab[i]) begin
      use_typed = dir_tab[i].fixed;
      typed_has = dir_tab[i].has;
      typed_res = dir_tab[i].res;
      offer_beat(dir_tab[i].op, dir_tab[i].pix);
    end
    use_typed = 1'b0;
    frames_done++;

    // random frames, sender 31% / receiver 45% idle
    goal = items_done + RAND_ITEMS / 3;
    random_frame(1, 1);
    while (items_done < goal) random_frame($urandom_range(99) < 60, 1);

    // swap idle ratios
    tx_idle = 45;
    rx_idle = 31;
    goal = items_done + RAND_ITEMS / 3;
    random_frame(1, 1);
    while (items_done < goal) random_frame($urandom_range(99) < 60, 1);

    // no idling: a one-pixel-wide frame (width 0 acting as 1), then random
    // frames under receiver hold-offs, then random frames without them
    tx_idle = 0;
    rx_idle = 0;
    wait_quiet();
    reg_write(REG_WIDTH, 13'd0);
    reg_write(REG_HEIGHT, 13'd9);
    random_frame(0, 0);
    hold_rx = 1'b1;
    goal = items_done + RAND_ITEMS / 6;
    random_frame(1, 1);
    while (items_done < goal) random_frame($urandom_range(99) < 60, 1);
    hold_rx = 1'b0;
    goal = items_done + RAND_ITEMS / 6;
    while (items_done < goal) random_frame($urandom_range(99) < 60, 1);

    // wind down: all owed results, then a wait for stray extras
    s_tvalid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d frames, %0d effective input beats, %0d results checked",
             frames_done, items_done, results_seen);
    $display("sizes 0 (as 1) up to 40 per side, mid-frame size changes, stray drains and pixels,"
             , " stalls both ways");
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== box_filter_5x5_stream.f =====
+incdir+rtl
rtl/bf5_pkg.sv
rtl/bf5_ram.sv
rtl/bf5_front.sv
rtl/bf5_fifo.sv
rtl/bf5_back.sv
rtl/box_filter_5x5_stream.sv
dv/box_filter_5x5_stream_tb.sv
